[rtl/i2cps_pkg.sv]
// Package for the I2C master pin sequencer.
// Holds command codes, hold times, the pin setting type and the stop helper.
// No dependencies.
package i2cps_pkg;

  localparam int unsigned I2CPS_CLEAR_PULSES = 28;

  localparam int unsigned REQ_W  = 3;
  localparam int unsigned HOLD_W = 4;

  localparam logic [REQ_W-1:0] CMD_START = 3'd0;
  localparam logic [REQ_W-1:0] CMD_STOP  = 3'd1;
  localparam logic [REQ_W-1:0] CMD_WRITE = 3'd2;
  localparam logic [REQ_W-1:0] CMD_RDACK = 3'd3;
  localparam logic [REQ_W-1:0] CMD_DRACK = 3'd4;
  localparam logic [REQ_W-1:0] CMD_CLEAR = 3'd5;

  localparam logic [HOLD_W-1:0] HOLD_STD  = 4'd5;
  localparam logic [HOLD_W-1:0] HOLD_LONG = 4'd8;

  typedef struct packed {
    logic              sda;
    logic              scl;
    logic [HOLD_W-1:0] hold;
    logic              sample;
    logic              ack;
    logic              last;
  } setting_t;

  // Stop condition: current levels, SDA low, SCL high, SDA high.
  function automatic setting_t stop_setting(input logic [1:0] k, input logic d,
                                            input logic s);
    setting_t r;
    r        = '0;
    r.hold   = HOLD_STD;
    case (k)
      2'd0: begin
        r.sda = d;
        r.scl = s;
      end
      2'd1: begin
        r.sda = 1'b0;
        r.scl = s;
      end
      2'd2: begin
        r.sda = 1'b0;
        r.scl = 1'b1;
      end
      default: begin
        r.sda = 1'b1;
        r.scl = 1'b1;
      end
    endcase
    return r;
  endfunction

endpackage

[rtl/i2cps_gen.sv]
// Step sequencer of the I2C master pin sequencer.
// Walks a command a step per cycle while adv is high; shifts data out bit by bit.
// Depends on i2cps_pkg.
module i2cps_gen #(
  parameter int unsigned CLEAR_PULSES = i2cps_pkg::I2CPS_CLEAR_PULSES
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [i2cps_pkg::REQ_W-1:0] in_req,
  input  logic [7:0]               in_byte,
  input  logic                     in_lvl,
  input  logic                     in_sda,
  input  logic                     adv,
  output logic                     set_valid,
  output i2cps_pkg::setting_t      set_o
);
  import i2cps_pkg::*;

  localparam int unsigned WR_LAST   = 25;
  localparam int unsigned CLR_STOP  = 3 + 2 * CLEAR_PULSES;
  localparam int unsigned CLR_LAST  = CLR_STOP + 3;
  localparam int unsigned STEP_MAX  = (CLR_LAST > WR_LAST) ? CLR_LAST : WR_LAST;
  localparam int unsigned STEP_W    = $clog2(STEP_MAX + 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t             state_r, state_nxt;
  logic [REQ_W-1:0]   cmd_r, cmd_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [1:0]         ph_r, ph_nxt;
  logic [2:0]         bit_r, bit_nxt;
  logic [7:0]         sr_r, sr_nxt;
  logic               lvl_r, lvl_nxt;
  logic               ack_r, ack_nxt;
  logic               last_sda_r, last_sda_nxt;
  logic               last_scl_r, last_scl_nxt;

  setting_t           set_c;
  logic [STEP_W-1:0]  clr_k;
  logic               cmd_ok;
  logic               emit;

  assign in_ready  = (state_r == ST_IDLE);
  assign set_valid = (state_r == ST_RUN);
  assign set_o     = set_c;
  assign emit      = set_valid && adv;
  assign cmd_ok    = (in_req == CMD_START) || (in_req == CMD_STOP)  ||
                     (in_req == CMD_WRITE) || (in_req == CMD_RDACK) ||
                     (in_req == CMD_DRACK) || (in_req == CMD_CLEAR);
  assign clr_k     = step_r - STEP_W'(CLR_STOP);

  always_comb begin
    set_c      = '0;
    set_c.sda  = last_sda_r;
    set_c.scl  = last_scl_r;
    set_c.hold = HOLD_STD;
    case (cmd_r)
      CMD_START: begin
        set_c.sda  = (step_r != STEP_W'(2));
        set_c.scl  = (step_r == STEP_W'(0)) ? last_scl_r : 1'b1;
        set_c.last = (step_r == STEP_W'(2));
      end
      CMD_STOP: begin
        set_c      = stop_setting(step_r[1:0], last_sda_r, last_scl_r);
        set_c.last = (step_r == STEP_W'(3));
      end
      CMD_WRITE: begin
        if (step_r == STEP_W'(1)) begin
          set_c.scl = 1'b0;
        end else if (step_r != STEP_W'(0)) begin
          set_c.sda  = sr_r[7];
          set_c.scl  = (ph_r == 2'd1);
          set_c.hold = ((ph_r == 2'd1) && (bit_r == 3'd7)) ? HOLD_LONG : HOLD_STD;
          set_c.last = (ph_r == 2'd2) && (bit_r == 3'd7);
        end
      end
      CMD_RDACK: begin
        set_c.sda    = (step_r == STEP_W'(0)) ? last_sda_r : 1'b1;
        set_c.scl    = (step_r == STEP_W'(2)) || (step_r == STEP_W'(3));
        set_c.sample = (step_r == STEP_W'(2));
        set_c.ack    = (step_r == STEP_W'(4)) && ack_r;
        set_c.last   = (step_r == STEP_W'(4));
      end
      CMD_DRACK: begin
        if (step_r == STEP_W'(0)) begin
          set_c.sda = last_sda_r;
        end else if (step_r == STEP_W'(4)) begin
          set_c.sda = 1'b1;
        end else begin
          set_c.sda = lvl_r;
        end
        set_c.scl  = (step_r == STEP_W'(2));
        set_c.hold = (step_r == STEP_W'(2)) ? HOLD_LONG : HOLD_STD;
        set_c.last = (step_r == STEP_W'(4));
      end
      CMD_CLEAR: begin
        if (step_r < STEP_W'(3)) begin
          set_c.sda = (step_r != STEP_W'(1));
          set_c.scl = 1'b0;
        end else if (step_r < STEP_W'(CLR_STOP)) begin
          set_c.sda = 1'b1;
          set_c.scl = ~step_r[0];
        end else begin
          set_c      = stop_setting(clr_k[1:0], last_sda_r, last_scl_r);
          set_c.last = (step_r == STEP_W'(CLR_LAST));
        end
      end
      default: begin
        set_c.last = 1'b1;
      end
    endcase
  end

  always_comb begin
    state_nxt    = state_r;
    cmd_nxt      = cmd_r;
    step_nxt     = step_r;
    ph_nxt       = ph_r;
    bit_nxt      = bit_r;
    sr_nxt       = sr_r;
    lvl_nxt      = lvl_r;
    ack_nxt      = ack_r;
    last_sda_nxt = last_sda_r;
    last_scl_nxt = last_scl_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && cmd_ok) begin
          state_nxt = ST_RUN;
          cmd_nxt   = in_req;
          step_nxt  = '0;
          ph_nxt    = 2'd0;
          bit_nxt   = 3'd0;
          sr_nxt    = in_byte;
          lvl_nxt   = in_lvl;
          ack_nxt   = ~in_sda;
        end
      end
      ST_RUN: begin
        if (emit) begin
          last_sda_nxt = set_c.sda;
          last_scl_nxt = set_c.scl;
          if (set_c.last) begin
            state_nxt = ST_IDLE;
          end else begin
            step_nxt = step_r + STEP_W'(1);
          end
          if ((cmd_r == CMD_WRITE) && (step_r >= STEP_W'(2))) begin
            if (ph_r == 2'd2) begin
              ph_nxt  = 2'd0;
              bit_nxt = bit_r + 3'd1;
              sr_nxt  = {sr_r[6:0], 1'b0};
            end else begin
              ph_nxt = ph_r + 2'd1;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      cmd_r      <= CMD_START;
      step_r     <= '0;
      ph_r       <= 2'd0;
      bit_r      <= 3'd0;
      last_sda_r <= 1'b0;
      last_scl_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cmd_r      <= cmd_nxt;
      step_r     <= step_nxt;
      ph_r       <= ph_nxt;
      bit_r      <= bit_nxt;
      last_sda_r <= last_sda_nxt;
      last_scl_r <= last_scl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sr_r  <= sr_nxt;
    lvl_r <= lvl_nxt;
    ack_r <= ack_nxt;
  end

  a_ph_range: assert property (@(posedge clk) disable iff (!rst_n)
    ph_r != 2'd3) else $error("write phase out of range");

  a_last_leaves: assert property (@(posedge clk) disable iff (!rst_n)
    emit && set_c.last |=> in_ready) else $error("run did not end on last");

  a_stop_release: assert property (@(posedge clk) disable iff (!rst_n)
    emit && set_c.last && ((cmd_r == CMD_STOP) || (cmd_r == CMD_CLEAR))
    |-> set_c.sda && set_c.scl) else $error("stop left a line driven low");

endmodule

[rtl/i2c_master_pin_sequencer.sv]
// Top level of the I2C master pin sequencer.
// Instantiates the step sequencer and the output register; depends on i2cps_pkg.
//
// Usage:
//   The in_ channel takes one bus command per item: start, stop, write byte,
//   read acknowledge, drive acknowledge or bus clear. Codes 6 and 7 are taken
//   and dropped without any result. The out_ channel gives the run of pin
//   settings the command calls for, one item per setting, with out_tlast on
//   the final setting of the run and out_tuser marking the SDA sample point.
//   Settings leave through the output register. Throughput: a command of N
//   settings (3 to 2*CLEAR_PULSES+7) occupies the sequencer until its last
//   setting is emitted, since the step counter emits one setting per cycle
//   while the output register can advance and a new command is taken only
//   once the last one is emitted; write byte shifts its data out of an 8-bit
//   shift register one bit per three steps. When out_tready is low with an
//   item held, the output register holds it and the step counter stops;
//   in_tready stays low until the run is finished.
//   Reset clears the sequencer to idle, drops any held result, and sets the
//   remembered SDA and SCL levels to zero.
module i2c_master_pin_sequencer #(
  parameter int unsigned CLEAR_PULSES = i2cps_pkg::I2CPS_CLEAR_PULSES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // req_type[2:0], data_byte[10:3], ack_level[11], sda_in[12]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // sda_out[0], scl_out[1], hold_units[5:2], ack_received[6]
  output logic [0:0]  out_tuser,  // sample_point[0]
  output logic        out_tlast
);
  import i2cps_pkg::*;

  logic     adv;
  logic     set_valid;
  setting_t set_c;
  logic     out_valid_r, out_valid_nxt;
  setting_t out_set_r;

  assign adv = !out_valid_r || out_tready;

  i2cps_gen #(
    .CLEAR_PULSES(CLEAR_PULSES)
  ) u_gen (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_req   (in_tdata[2:0]),
    .in_byte  (in_tdata[10:3]),
    .in_lvl   (in_tdata[11]),
    .in_sda   (in_tdata[12]),
    .adv      (adv),
    .set_valid(set_valid),
    .set_o    (set_c)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = set_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && set_valid) begin
      out_set_r <= set_c;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_set_r.ack, out_set_r.hold, out_set_r.scl, out_set_r.sda};
  assign out_tuser  = out_set_r.sample;
  assign out_tlast  = out_set_r.last;

  a_ack_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[6] |-> out_tlast) else $error("ack flag off the last setting");

  a_sample_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> (out_tdata[5:2] == HOLD_STD) && out_tdata[0] && out_tdata[1])
    else $error("bad sample point setting");

  a_cmd_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tdata[2:0] <= CMD_CLEAR) |=> !in_tready)
    else $error("command did not start a run");

endmodule
